[design/sbfe_pkg.sv]
// Package of shared widths, register codes, reset values and helper functions for the bit-flip event block.
`default_nettype none
package sbfe_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned PosW    = 3;
    localparam int unsigned CountW  = 4;
    localparam int unsigned AddrW   = 32;
    localparam int unsigned TimeW   = 64;
    localparam int unsigned EventW  = 36;
    localparam int unsigned RateW   = 16;
    localparam int unsigned CfgIdxW = 1;
    localparam int unsigned CfgW    = 36;
    localparam int unsigned InDataW  = 16;
    localparam int unsigned OutDataW = 136;

    localparam logic [EventW-1:0] MaxEventsReset = EventW'(64'h8_0000_0000);
    localparam logic [RateW-1:0]  NsPerByteReset = RateW'(1000);

    typedef enum logic [CfgIdxW-1:0] {
        REG_MAX_EVENTS  = 1'b0,
        REG_NS_PER_BYTE = 1'b1
    } t_cfg_reg;

    function automatic logic [CountW-1:0] f_popcount(input logic [ByteW-1:0] value);
        logic [CountW-1:0] sum;
        sum = '0;
        for (int i = 0; i < ByteW; i++) begin
            sum = sum + CountW'(value[i]);
        end
        return sum;
    endfunction

    function automatic logic [PosW-1:0] f_lowest_set(input logic [ByteW-1:0] value);
        logic [PosW-1:0] pos;
        pos = '0;
        for (int i = ByteW - 1; i >= 0; i--) begin
            if (value[i]) begin
                pos = PosW'(i);
            end
        end
        return pos;
    endfunction

endpackage
`default_nettype wire

[design/snapshot_bit_flip_events.sv]
// Top level: compares snapshot bytes and emits one event per flipped bit, up to the configured limit.
// Each byte is captured in the emit-stage registers, and its events then leave through the output register.
// Throughput: one byte per cycle while each byte yields at most one event and the output is not held;
// a byte yielding several events occupies the single event-emit stage until its last event is emitted.
// A byte with no events waits only while the emit stage is busy, which a held output can prolong.
// Synchronous active-low reset clears position, time, count and pending events and
// restores both configuration registers to their defaults.
`default_nettype none
module snapshot_bit_flip_events (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wen,
    input  wire logic [sbfe_pkg::CfgIdxW-1:0]     i_cfg_idx,
    input  wire logic [sbfe_pkg::CfgW-1:0]        i_cfg_wdata,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // old_byte [7:0], new_byte [15:8]
    input  wire logic [sbfe_pkg::InDataW-1:0]     s_axis_tdata,
    input  wire logic                             s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // event time [63:0], address [95:64], flipped bit index [98:96],
    // direction [99], event_number [135:100]
    output logic [sbfe_pkg::OutDataW-1:0]         m_axis_tdata,
    output logic                                  m_axis_tlast
);
    import sbfe_pkg::*;

    logic [EventW-1:0] r_max;
    logic [RateW-1:0]  r_nspb;
    logic [AddrW-1:0]  r_index;
    logic [TimeW-1:0]  r_time;
    logic [EventW-1:0] r_count;

    logic              r_busy;
    logic [ByteW-1:0]  r_mask;
    logic [CountW-1:0] r_cnt;
    logic [ByteW-1:0]  r_newb;
    logic [TimeW-1:0]  r_ts;
    logic [AddrW-1:0]  r_addr;
    logic [EventW-1:0] r_evn;

    logic              r_ovalid;
    logic [OutDataW-1:0] r_odata;
    logic              r_olast;

    logic [ByteW-1:0]  in_diff;
    logic [CountW-1:0] in_pop;
    logic [EventW-1:0] budget;
    logic [CountW-1:0] n_emit;
    logic              in_acc;
    logic              emit;
    logic [PosW-1:0]   emit_pos;
    logic              emit_last;

    assign in_diff = s_axis_tdata[7:0] ^ s_axis_tdata[15:8];
    assign in_pop  = f_popcount(in_diff);
    assign budget  = (r_count < r_max) ? (r_max - r_count) : '0;
    assign n_emit  = (budget < EventW'(in_pop)) ? budget[CountW-1:0] : in_pop;

    assign emit      = r_busy && (!r_ovalid || m_axis_tready);
    assign emit_pos  = f_lowest_set(r_mask);
    assign emit_last = (r_cnt == CountW'(1));

    assign s_axis_tready = !r_busy || (emit && emit_last);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max  <= MaxEventsReset;
            r_nspb <= NsPerByteReset;
        end else if (i_cfg_wen) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_MAX_EVENTS:  r_max  <= i_cfg_wdata[EventW-1:0];
                REG_NS_PER_BYTE: r_nspb <= i_cfg_wdata[RateW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
            r_time  <= '0;
            r_count <= '0;
        end else if (in_acc) begin
            if (s_axis_tlast) begin
                r_index <= '0;
                r_time  <= '0;
                r_count <= '0;
            end else begin
                r_index <= r_index + AddrW'(1);
                r_time  <= r_time + TimeW'(r_nspb);
                r_count <= r_count + EventW'(n_emit);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (in_acc) begin
            r_busy <= (n_emit != '0);
        end else if (emit && emit_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mask <= in_diff;
            r_cnt  <= n_emit;
            r_newb <= s_axis_tdata[15:8];
            r_ts   <= r_time;
            r_addr <= r_index;
            r_evn  <= r_count + EventW'(1);
        end else if (emit) begin
            r_mask[emit_pos] <= 1'b0;
            r_cnt            <= r_cnt - CountW'(1);
            r_evn            <= r_evn + EventW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_odata <= {r_evn, r_newb[emit_pos], emit_pos, r_addr, r_ts};
            r_olast <= emit_last;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    a_busy_has_events: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("emit stage busy with no events left");

    a_cnt_within_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (32'(r_cnt) <= $countones(r_mask)))
        else $error("more events pending than flipped bits");

    a_event_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (r_evn <= r_max))
        else $error("event number beyond configured maximum");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tlast) |=> (r_count == '0 && r_index == '0 && r_time == '0))
        else $error("snapshot state not cleared after last byte");

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the snapshot bit-flip event block.
`timescale 1ns / 100ps

module testbench;
    import sbfe_pkg::*;

    typedef struct {
        logic [7:0] old_b;
        logic [7:0] new_b;
        logic       last;
    } t_byte_pair;

    typedef struct {
        logic [TimeW-1:0]  timestamp;
        logic [AddrW-1:0]  address;
        logic [PosW-1:0]   bit_pos;
        logic              direction;
        logic [EventW-1:0] event_num;
        logic              last_of_run;
    } t_flip_event;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_wen = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx = '0;
    logic [CfgW-1:0]     i_cfg_wdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata = '0;
    logic                s_axis_tlast = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;
    logic                m_axis_tlast;

    t_byte_pair  byte_pairs_pending[$];
    t_flip_event flip_events_due[$];

    logic [AddrW-1:0]  snap_byte_addr = '0;
    logic [TimeW-1:0]  snap_time_ns = '0;
    logic [EventW-1:0] snap_event_count = '0;
    logic [EventW-1:0] limit_events = MaxEventsReset;
    logic [RateW-1:0]  rate_ns_per_byte = NsPerByteReset;

    int   sender_idle_pct = 29;
    int   receiver_idle_pct = 67;
    logic rx_hold = 1'b0;
    bit   hold_armed = 1'b0;

    int error_count = 0;
    int bytes_accepted = 0;
    int events_checked = 0;
    int snapshots_closed = 0;

    snapshot_bit_flip_events dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic void predict_flip_events(logic [7:0] old_b, logic [7:0] new_b,
                                                logic last);
        logic [7:0]  diff;
        t_flip_event ev;
        t_flip_event run[$];
        diff = old_b ^ new_b;
        for (int b = 0; b < 8; b++) begin
            if (diff[b] && snap_event_count < limit_events) begin
                snap_event_count = snap_event_count + 1'b1;
                ev.timestamp   = snap_time_ns;
                ev.address     = snap_byte_addr;
                ev.bit_pos     = PosW'(b);
                ev.direction   = new_b[b];
                ev.event_num   = snap_event_count;
                ev.last_of_run = 1'b0;
                run.push_back(ev);
            end
        end
        if (run.size() > 0) begin
            run[run.size() - 1].last_of_run = 1'b1;
        end
        foreach (run[k]) begin
            flip_events_due.push_back(run[k]);
        end
        if (last) begin
            snap_byte_addr   = '0;
            snap_time_ns     = '0;
            snap_event_count = '0;
        end else begin
            snap_byte_addr = snap_byte_addr + 1'b1;
            snap_time_ns   = snap_time_ns + TimeW'(rate_ns_per_byte);
        end
    endfunction

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Driver: presents pending byte pairs and updates the prediction on each transaction.
    always @(posedge i_clk) begin
        t_byte_pair nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_flip_events(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tlast);
                bytes_accepted++;
                if (s_axis_tlast) begin
                    snapshots_closed++;
                end
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (byte_pairs_pending.size() > 0 &&
                    $urandom_range(99) >= sender_idle_pct) begin
                    nxt = byte_pairs_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {nxt.new_b, nxt.old_b};
                    s_axis_tlast  <= nxt.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each event transaction against the oldest prediction.
    always @(posedge i_clk) begin
        t_flip_event want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (flip_events_due.size() == 0) begin
                $error("unexpected event: address %0d, flip_bit %0d",
                       m_axis_tdata[95:64], m_axis_tdata[98:96]);
                error_count++;
            end else begin
                want = flip_events_due.pop_front();
                compare_field("event_time", want.timestamp, m_axis_tdata[63:0]);
                compare_field("address", 64'(want.address), 64'(m_axis_tdata[95:64]));
                compare_field("flip_bit", 64'(want.bit_pos), 64'(m_axis_tdata[98:96]));
                compare_field("direction", 64'(want.direction), 64'(m_axis_tdata[99]));
                compare_field("event_number", 64'(want.event_num),
                              64'(m_axis_tdata[135:100]));
                compare_field("last_of_run", 64'(want.last_of_run), 64'(m_axis_tlast));
                events_checked++;
            end
        end
        m_axis_tready <= i_rst_n && !rx_hold && ($urandom_range(99) >= receiver_idle_pct);
    end

    // Long receiver hold-off so that the block fills up and stalls its input.
    initial begin
        wait (hold_armed);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (80) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("testbench: errors");
        $finish;
    end

    task automatic queue_pair(logic [7:0] old_b, logic [7:0] new_b, logic last);
        t_byte_pair p;
        p.old_b = old_b;
        p.new_b = new_b;
        p.last  = last;
        byte_pairs_pending.push_back(p);
    endtask

    task automatic queue_random_snapshots(int n_bytes);
        int         added;
        int         run_len;
        int         kind;
        bit         broken;
        logic [7:0] o;
        logic [7:0] nw;
        added = 0;
        while (added < n_bytes) begin
            run_len = $urandom_range(1, 12);
            broken  = ($urandom_range(9) == 0);
            for (int k = 0; k < run_len; k++) begin
                o    = 8'($urandom_range(255));
                kind = $urandom_range(99);
                if (kind < 15) begin
                    nw = o;
                end else if (kind < 60) begin
                    nw = o ^ (8'd1 << $urandom_range(7));
                end else if (kind < 85) begin
                    nw = o ^ (8'd1 << $urandom_range(7)) ^ (8'd1 << $urandom_range(7));
                end else begin
                    nw = 8'($urandom_range(255));
                end
                queue_pair(o, nw, broken ? 1'($urandom_range(1)) : (k == run_len - 1));
                added++;
            end
        end
    endtask

    task automatic write_register(t_cfg_reg idx, logic [CfgW-1:0] value);
        @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        if (idx == REG_MAX_EVENTS) begin
            limit_events = value[EventW-1:0];
        end else begin
            rate_ns_per_byte = value[RateW-1:0];
        end
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
    endtask

    task automatic wait_until_idle();
        while (byte_pairs_pending.size() != 0 || s_axis_tvalid ||
               flip_events_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Equal bytes, full flips both ways, single flips, last byte with and without events.
        queue_pair(8'h00, 8'h00, 1'b0);
        queue_pair(8'h00, 8'hFF, 1'b0);
        queue_pair(8'hFF, 8'h00, 1'b0);
        queue_pair(8'hFF, 8'hFF, 1'b0);
        queue_pair(8'h01, 8'h00, 1'b0);
        queue_pair(8'h00, 8'h80, 1'b0);
        queue_pair(8'hA5, 8'h5A, 1'b1);
        queue_pair(8'h00, 8'h00, 1'b1);
        queue_pair(8'h3C, 8'hC3, 1'b0);
        queue_pair(8'h12, 8'h34, 1'b0);
        wait_until_idle();

        // The limit drops below the count already reached in the open snapshot.
        write_register(REG_MAX_EVENTS, 36'd3);
        queue_pair(8'h0F, 8'hF0, 1'b0);
        queue_pair(8'hFF, 8'h00, 1'b1);
        queue_pair(8'h00, 8'h0F, 1'b0);
        queue_pair(8'h00, 8'h01, 1'b1);
        queue_pair(8'hF0, 8'h00, 1'b0);
        wait_until_idle();

        // Rate change part-way through a snapshot, and a zero limit.
        write_register(REG_NS_PER_BYTE, 36'd65535);
        write_register(REG_MAX_EVENTS, 36'd0);
        queue_pair(8'hFF, 8'h00, 1'b0);
        queue_pair(8'h00, 8'hFF, 1'b0);
        queue_pair(8'h55, 8'hAA, 1'b1);
        wait_until_idle();

        write_register(REG_MAX_EVENTS, '1);
        write_register(REG_NS_PER_BYTE, 36'd0);
        queue_pair(8'h81, 8'h18, 1'b0);
        queue_pair(8'h00, 8'h00, 1'b0);
        queue_pair(8'hFF, 8'hFE, 1'b1);
        wait_until_idle();

        write_register(REG_MAX_EVENTS, CfgW'(MaxEventsReset));
        write_register(REG_NS_PER_BYTE, CfgW'($urandom_range(65535)));
        queue_random_snapshots(63);
        wait_until_idle();

        sender_idle_pct   = 67;
        receiver_idle_pct = 29;
        write_register(REG_MAX_EVENTS, CfgW'($urandom_range(12)));
        write_register(REG_NS_PER_BYTE, 36'd65535);
        queue_random_snapshots(63);
        wait_until_idle();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        write_register(REG_MAX_EVENTS, CfgW'($urandom_range(1, 40)));
        write_register(REG_NS_PER_BYTE, CfgW'($urandom_range(65535)));
        queue_random_snapshots(63);
        hold_armed = 1'b1;
        wait_until_idle();

        $display("Covered %0d byte pairs over %0d closed snapshots, %0d events checked.",
                 bytes_accepted, snapshots_closed, events_checked);
        $display("Limits from zero to full width and rates from 0 to 65535 ns were used.");
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
